// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; each file that asserts includes it once.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PCTH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PCTH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pcth_pkg.sv =====
// Shared types, constants and helper functions of the tier hysteresis block.
// Depends on nothing; every module of the block uses it.
`default_nettype none

package pcth_pkg;

  localparam int CELLS     = 4096;
  localparam int MAX_TIERS = 6;

  localparam int CELL_W  = 12;
  localparam int POP_W   = 32;
  localparam int TIER_W  = 3;
  localparam int BP_W    = 14;
  localparam int GEN_W   = 32;
  localparam int THR_N   = 5;
  localparam int PROD_W  = POP_W + BP_W;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int WIDE_W  = (ADDR_W > CELL_W) ? ADDR_W : CELL_W;
  localparam int STARTS  = 1 << TIER_W;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [BP_W-1:0]   BP_SCALE = BP_W'(10000);
  localparam logic [31:0]       CELLS_U  = 32'(CELLS);
  localparam logic [TIER_W-1:0] MAX_TIERS_T = TIER_W'(MAX_TIERS);

  typedef enum logic [2:0] {
    REG_TIER_COUNT  = 3'd0,
    REG_DOWNGRADE   = 3'd1,
    REG_NAMED_TIER  = 3'd2,
    REG_THR_ONE     = 3'd3,
    REG_THR_TWO     = 3'd4,
    REG_THR_THREE   = 3'd5,
    REG_THR_FOUR    = 3'd6,
    REG_THR_FIVE    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_INIT   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [TIER_W-1:0]              tier_count;
    logic [BP_W-1:0]                downgrade_bp;
    logic [TIER_W-1:0]              named_tier;
    logic [THR_N:1][POP_W-1:0]      thr;
  } cfg_t;

  // Resulting tier for every possible starting tier.
  typedef logic [STARTS-1:0][TIER_W-1:0] tier_vec_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CELL_W-1:0] cell_idx;
    logic              forced;
    tier_vec_t         res;
  } q_entry_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [TIER_W-1:0] tier;
  } rec_t;

  localparam cfg_t CFG_RESET = '{
    tier_count:   TIER_W'(6),
    downgrade_bp: BP_W'(8000),
    named_tier:   TIER_W'(1),
    thr:          {POP_W'(1000000), POP_W'(100000), POP_W'(10000),
                   POP_W'(1000), POP_W'(100)}
  };

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] idx);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(idx);
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic cell_in_range(input logic [CELL_W-1:0] idx);
    return 32'(idx) < CELLS_U;
  endfunction

  // ge[i]: population reaches threshold i. keep[i]: population is not below
  // the demotion level of tier i. Bit 0 of both is unused and held high.
  function automatic tier_vec_t classify_all(input logic [TIER_W-1:0] tier_count,
                                             input logic [THR_N:0]    ge,
                                             input logic [THR_N:0]    keep);
    logic [TIER_W-1:0] n;
    logic [TIER_W-1:0] t;
    logic [TIER_W-1:0] tp1;
    logic [TIER_W-1:0] st;
    tier_vec_t         res;
    n = (tier_count > MAX_TIERS_T) ? MAX_TIERS_T : tier_count;
    for (int s = 0; s < STARTS; s++) begin
      st = TIER_W'(s);
      if (n == '0) begin
        t = '0;
      end else begin
        t = (st < n - TIER_W'(1)) ? st : n - TIER_W'(1);
        for (int k = 0; k < THR_N; k++) begin
          tp1 = t + TIER_W'(1);
          if (tp1 < n && ge[tp1]) t = tp1;
        end
        for (int k = 0; k < THR_N; k++) begin
          if (t != '0 && !keep[t]) t = t - TIER_W'(1);
        end
      end
      res[s] = t;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/pcth_queue.sv =====
// Short request queue between the classifying front end and the store back end.
// Depends on pcth_pkg for the entry type and depth.
`default_nettype none

module pcth_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  pcth_pkg::q_entry_t  push_data,
  output logic                push_ready,
  output logic                head_valid,
  output pcth_pkg::q_entry_t  head_data,
  input  wire                 pop
);
  import pcth_pkg::*;

  q_entry_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != Q_CNT_W'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== src/pcth_front.sv =====
// Front end: accepts requests and works out the resulting tier for every
// possible starting tier. Depends on pcth_pkg; feeds pcth_queue.
`default_nettype none

module pcth_front (
  input  wire                        clk,
  input  wire                        rst,
  input  pcth_pkg::cfg_t             cfg,
  input  wire                        hold,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  pcth_pkg::cmd_t             in_cmd,
  input  wire [pcth_pkg::CELL_W-1:0] in_cell,
  input  wire [pcth_pkg::POP_W-1:0]  in_pop,
  input  wire                        in_forced,
  output logic                       push,
  output pcth_pkg::q_entry_t         push_data,
  input  wire                        q_ready
);
  import pcth_pkg::*;

  // Threshold times basis points, refreshed every cycle from the registers.
  logic [THR_N:1][PROD_W-1:0] prod;

  logic              f1_valid;
  cmd_t              f1_cmd;
  logic [CELL_W-1:0] f1_cell;
  logic              f1_forced;
  logic [PROD_W-1:0] f1_pop_scaled;
  logic [THR_N:0]    f1_ge;

  logic              f2_valid;
  cmd_t              f2_cmd;
  logic [CELL_W-1:0] f2_cell;
  logic              f2_forced;
  logic [THR_N:0]    f2_ge;
  logic [THR_N:0]    f2_keep;

  logic              f2_move;
  logic              f1_move;
  logic              in_take;
  logic [THR_N:0]    ge_d;
  logic [THR_N:0]    keep_d;

  assign f2_move  = f2_valid && q_ready;
  assign f1_move  = f1_valid && (!f2_valid || f2_move);
  assign in_ready = !hold && (!f1_valid || f1_move);
  assign in_take  = in_valid && in_ready;

  // pop >= ceil(thr * bp / 10000) holds exactly when thr * bp <= pop * 10000.
  always_comb begin
    ge_d[0]   = 1'b1;
    keep_d[0] = 1'b1;
    for (int i = 1; i <= THR_N; i++) begin
      ge_d[i]   = in_pop >= cfg.thr[i];
      keep_d[i] = prod[i] <= f1_pop_scaled;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= THR_N; i++) begin
      prod[i] <= PROD_W'(cfg.thr[i]) * PROD_W'(cfg.downgrade_bp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (in_take) begin
        f1_valid <= 1'b1;
      end else if (f1_move) begin
        f1_valid <= 1'b0;
      end
      if (f1_move) begin
        f2_valid <= 1'b1;
      end else if (f2_move) begin
        f2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      f1_cmd        <= in_cmd;
      f1_cell       <= in_cell;
      f1_forced     <= in_forced;
      f1_pop_scaled <= PROD_W'(in_pop) * PROD_W'(BP_SCALE);
      f1_ge         <= ge_d;
    end
    if (f1_move) begin
      f2_cmd    <= f1_cmd;
      f2_cell   <= f1_cell;
      f2_forced <= f1_forced;
      f2_ge     <= f1_ge;
      f2_keep   <= keep_d;
    end
  end

  assign push = f2_valid;

  always_comb begin
    push_data.cmd      = f2_cmd;
    push_data.cell_idx = f2_cell;
    push_data.forced   = f2_forced;
    push_data.res      = classify_all(cfg.tier_count, f2_ge, f2_keep);
  end

endmodule

`default_nettype wire

// ===== src/pcth_back.sv =====
// Back end: per-cell tier and generation store with read-modify-write,
// forwarding of the latest write, clearing pass and output register.
// Depends on pcth_pkg; takes requests from pcth_queue.
`default_nettype none

module pcth_back (
  input  wire                              clk,
  input  wire                              rst,
  input  pcth_pkg::cfg_t                   cfg,
  input  wire                              head_valid,
  input  pcth_pkg::q_entry_t               head_data,
  output logic                             pop,
  output logic                             busy,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [pcth_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import pcth_pkg::*;

  rec_t              mem [CELLS];
  rec_t              mem_q;

  logic [ADDR_W-1:0] clr_addr;

  logic              b2_valid;
  q_entry_t          b2_entry;

  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  rec_t              fwd_rec;

  logic [TIER_W-1:0] out_old;
  logic [TIER_W-1:0] out_new;
  logic              out_chg;
  logic              out_up;
  logic              out_asg;
  logic              out_rel;
  logic [GEN_W-1:0]  out_gen;

  logic              out_free;
  logic              b2_move;
  logic [ADDR_W-1:0] b2_addr;
  logic              b2_ok;
  rec_t              cur;
  logic [TIER_W-1:0] prior_tier;
  logic [TIER_W-1:0] after;
  logic              chg;
  logic              up;
  logic              asg;
  logic              rel;
  logic [GEN_W-1:0]  gen;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rec_t              wr_data;

  assign out_free = !m_tvalid || m_tready;
  assign b2_move  = b2_valid && out_free;
  assign pop      = head_valid && !busy && (!b2_valid || b2_move);
  assign b2_addr  = cell_addr(b2_entry.cell_idx);
  assign b2_ok    = cell_in_range(b2_entry.cell_idx);

  // The read of this request may have coincided with the write of the one
  // ahead of it; the latest write always holds the freshest record.
  assign cur = (fwd_valid && fwd_addr == b2_addr) ? fwd_rec : mem_q;

  always_comb begin
    prior_tier = '0;
    after      = '0;
    chg        = 1'b0;
    up         = 1'b0;
    asg        = 1'b0;
    rel        = 1'b0;
    gen        = '0;
    if (b2_ok) begin
      if (b2_entry.cmd == CMD_INIT) begin
        after = b2_entry.res[0];
        asg   = after >= cfg.named_tier;
      end else begin
        prior_tier = cur.tier;
        after      = b2_entry.res[prior_tier];
        chg        = after != prior_tier;
        up         = chg && (after > prior_tier);
        gen        = chg ? cur.gen + GEN_W'(1) : cur.gen;
        asg        = chg && prior_tier < cfg.named_tier && after >= cfg.named_tier;
        rel        = chg && prior_tier >= cfg.named_tier && after < cfg.named_tier
                     && !b2_entry.forced;
      end
    end
  end

  assign wr_en   = busy || (b2_move && b2_ok);
  assign wr_addr = busy ? clr_addr : b2_addr;
  assign wr_data = busy ? '0 : rec_t'{gen: gen, tier: after};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (pop) mem_q <= mem[cell_addr(head_data.cell_idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clr_addr  <= '0;
      b2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (busy) begin
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          busy <= 1'b0;
        end else begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
      end
      if (pop) begin
        b2_valid <= 1'b1;
      end else if (b2_move) begin
        b2_valid <= 1'b0;
      end
      if (b2_move && b2_ok) begin
        fwd_valid <= 1'b1;
      end
      if (b2_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) b2_entry <= head_data;
    if (b2_move && b2_ok) begin
      fwd_addr <= b2_addr;
      fwd_rec  <= wr_data;
    end
    if (b2_move) begin
      out_old <= prior_tier;
      out_new <= after;
      out_chg <= chg;
      out_up  <= up;
      out_asg <= asg;
      out_rel <= rel;
      out_gen <= gen;
    end
  end

  assign m_tdata = {6'd0, out_gen, out_rel, out_asg, out_up, out_chg, out_new, out_old};

endmodule

`default_nettype wire

// ===== src/per_cell_tier_hysteresis_top.sv =====
// Per-cell tier classifier with hysteresis: one request in and one result out
// per cycle, sustained while the output is not stalled, with each request going
// through front stages f1 and f2, the queue, back stage b2 and the output
// register. The rate is set by the per-cell store, one read and one write per
// cycle with the latest write forwarded, so requests for the same cell may
// follow each other back to back. After reset the store is cleared in a pass
// over all 4096 cells, one cell per cycle, during which s_tready stays low;
// configuration writes are taken at any time and should only be made while no
// request is in flight. Holds the configuration registers; depends on pcth_pkg,
// pcth_front, pcth_queue and pcth_back.
`default_nettype none

module per_cell_tier_hysteresis_top (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // bits 11:0 cell_index, 43:12 population, 44 pinned-name flag, 47:45 zero
  input  wire [pcth_pkg::IN_TDATA_W-1:0]   s_tdata,
  // bit 0 cmd
  input  wire                              s_tuser,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // bits 2:0 old_tier, 5:3 new_tier, 6 tier_changed, 7 promoted,
  // 8 name_assign, 9 name_release, 41:10 change_generation, 47:42 zero
  output logic [pcth_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire                              cfg_we,
  input  wire [2:0]                        cfg_addr,
  input  wire [31:0]                       cfg_wdata
);
  import pcth_pkg::*;

  cfg_t      cfg;
  logic      busy;
  logic      push;
  q_entry_t  push_data;
  logic      q_ready;
  logic      head_valid;
  q_entry_t  head_data;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_TIER_COUNT: cfg.tier_count   <= cfg_wdata[TIER_W-1:0];
        REG_DOWNGRADE:  cfg.downgrade_bp <= cfg_wdata[BP_W-1:0];
        REG_NAMED_TIER: cfg.named_tier   <= cfg_wdata[TIER_W-1:0];
        REG_THR_ONE:    cfg.thr[1]       <= cfg_wdata;
        REG_THR_TWO:    cfg.thr[2]       <= cfg_wdata;
        REG_THR_THREE:  cfg.thr[3]       <= cfg_wdata;
        REG_THR_FOUR:   cfg.thr[4]       <= cfg_wdata;
        REG_THR_FIVE:   cfg.thr[5]       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pcth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .hold      (busy),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (cmd_t'(s_tuser)),
    .in_cell   (s_tdata[11:0]),
    .in_pop    (s_tdata[43:12]),
    .in_forced (s_tdata[44]),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready)
  );

  pcth_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  pcth_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .busy       (busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

// ===== src/pcth_checker.sv =====
// Port-level checks of the tier hysteresis block, bound to its top level.
// Depends on assert_macros.svh and pcth_pkg.
`default_nettype none
`include "assert_macros.svh"

module pcth_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [pcth_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // The store clearing pass keeps the block closed right after reset.
  `PCTH_ASSERT_ALWAYS(a_closed_after_reset, clk, rst |=> !s_tready && !m_tvalid, "open after reset")

  `PCTH_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  `PCTH_ASSERT(a_promote, clk, rst, m_tvalid && m_tdata[7] |-> m_tdata[6] && (m_tdata[5:3] > m_tdata[2:0]), "promotion without rise")

  `PCTH_ASSERT(a_change, clk, rst, m_tvalid && m_tdata[6] |-> m_tdata[5:3] != m_tdata[2:0], "change flag with equal tiers")

  `PCTH_ASSERT(a_release, clk, rst, m_tvalid && m_tdata[9] |-> m_tdata[6] && !m_tdata[7] && !m_tdata[8], "release without demotion")

endmodule

bind per_cell_tier_hysteresis_top pcth_checker u_pcth_checker (.*);

`default_nettype wire

// ===== sim/per_cell_tier_hysteresis_top_tb.sv =====
// Self-checking testbench for the per-cell tier hysteresis block: it drives
// cell reports through the stream ports and checks every result against its own tier tracker.
// Depends on pcth_pkg and per_cell_tier_hysteresis_top.
`timescale 1ns / 1ps

module per_cell_tier_hysteresis_top_tb;
  import pcth_pkg::*;

  typedef struct packed {
    logic [GEN_W-1:0]  generation;
    logic              name_release;
    logic              name_assign;
    logic              promoted;
    logic              changed;
    logic [TIER_W-1:0] new_tier;
    logic [TIER_W-1:0] old_tier;
  } tier_result_t;

  typedef enum int {PACE_STEADY, PACE_BURSTY, PACE_SPARSE} send_pace_t;
  typedef enum int {DRAIN_FULL, DRAIN_RANDOM, DRAIN_PATTERN, DRAIN_STARVED} drain_t;

  // Tracks tier and change generation per cell and the results still owed.
  class tier_tracker;
    logic [TIER_W-1:0] tier_count;
    logic [BP_W-1:0]   downgrade_bp;
    logic [TIER_W-1:0] named_tier;
    logic [POP_W-1:0]  thr [1:5];
    logic [TIER_W-1:0] tier_mem [CELLS];
    logic [GEN_W-1:0]  gen_mem [CELLS];
    tier_result_t      pending [$];
    int                errors;

    function new();
      tier_count   = 3'd6;
      downgrade_bp = 14'd8000;
      named_tier   = 3'd1;
      thr[1] = 32'd100;
      thr[2] = 32'd1000;
      thr[3] = 32'd10000;
      thr[4] = 32'd100000;
      thr[5] = 32'd1000000;
      foreach (tier_mem[i]) begin
        tier_mem[i] = '0;
        gen_mem[i]  = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        REG_TIER_COUNT: tier_count   = v[TIER_W-1:0];
        REG_DOWNGRADE:  downgrade_bp = v[BP_W-1:0];
        REG_NAMED_TIER: named_tier   = v[TIER_W-1:0];
        REG_THR_ONE:    thr[1] = v;
        REG_THR_TWO:    thr[2] = v;
        REG_THR_THREE:  thr[3] = v;
        REG_THR_FOUR:   thr[4] = v;
        REG_THR_FIVE:   thr[5] = v;
      endcase
    endfunction

    // Population below this level drops a cell out of tier k (rounded up).
    function logic [63:0] demote_level(int k);
      return (64'(thr[k]) * 64'(downgrade_bp) + 64'd9999) / 64'd10000;
    endfunction

    function logic [TIER_W-1:0] settle_tier(logic [POP_W-1:0] pop, logic [TIER_W-1:0] start);
      int unsigned n;
      int unsigned t;
      n = (tier_count > MAX_TIERS) ? MAX_TIERS : tier_count;
      if (n == 0) return '0;
      t = (start < n - 1) ? start : n - 1;
      while (t + 1 < n && pop >= thr[t + 1]) t++;
      while (t > 0 && 64'(pop) < demote_level(t)) t--;
      return TIER_W'(t);
    endfunction

    function void note_request(cmd_t cmd, logic [CELL_W-1:0] cell_idx, logic [POP_W-1:0] pop,
                               logic forced);
      tier_result_t r;
      r = '0;
      if (cmd == CMD_INIT) begin
        r.new_tier         = settle_tier(pop, '0);
        tier_mem[cell_idx] = r.new_tier;
        gen_mem[cell_idx]  = '0;
        r.name_assign      = (r.new_tier >= named_tier);
      end else begin
        r.old_tier = tier_mem[cell_idx];
        r.new_tier = settle_tier(pop, r.old_tier);
        if (r.new_tier != r.old_tier) begin
          tier_mem[cell_idx] = r.new_tier;
          gen_mem[cell_idx]  = gen_mem[cell_idx] + 1;
          r.changed  = 1'b1;
          r.promoted = (r.new_tier > r.old_tier);
          if (r.old_tier < named_tier && r.new_tier >= named_tier)
            r.name_assign = 1'b1;
          else if (r.old_tier >= named_tier && r.new_tier < named_tier && !forced)
            r.name_release = 1'b1;
        end
      end
      r.generation = gen_mem[cell_idx];
      pending.insert(pending.size(), r);
    endfunction

    function void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      tier_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none, actual %h", $time, d);
        return;
      end
      e = pending[0];
      pending.delete(0);
      check_field("old_tier", 32'(e.old_tier), 32'(d[2:0]));
      check_field("new_tier", 32'(e.new_tier), 32'(d[5:3]));
      check_field("tier_changed", 32'(e.changed), 32'(d[6]));
      check_field("promoted", 32'(e.promoted), 32'(d[7]));
      check_field("name_assign", 32'(e.name_assign), 32'(d[8]));
      check_field("name_release", 32'(e.name_release), 32'(d[9]));
      check_field("change_generation", e.generation, d[41:10]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [2:0]             cfg_addr;
  logic [31:0]            cfg_wdata;

  tier_tracker tracker = new();

  send_pace_t        send_pace;
  drain_t            drain_mode;
  int                burst_left;
  int                ready_phase;
  logic [CELL_W-1:0] cell_pool [8] = '{12'd0, 12'd4095, 12'd1, 12'd2, 12'd7, 12'd100,
                                       12'd2048, 12'd3000};

  per_cell_tier_hysteresis_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver back-pressure, independent of the sender's pacing.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1;
    case (drain_mode)
      DRAIN_FULL:    m_tready <= 1'b1;
      DRAIN_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
      DRAIN_PATTERN: m_tready <= ((ready_phase % 7) > 2);
      default:       m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // Called right after a rising edge; returns at the edge that accepts the request.
  task automatic send_request(cmd_t cmd, logic [CELL_W-1:0] cell_idx, logic [POP_W-1:0] pop,
                              logic forced);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case (send_pace)
        PACE_STEADY: gap = 0;
        PACE_BURSTY: gap = $urandom_range(1, 4);
        default:     gap = $urandom_range(0, 12);
      endcase
    end
    burst_left--;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, forced, pop, cell_idx};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    tracker.note_request(cmd, cell_idx, pop, forced);
  endtask

  // Mostly populations right around a threshold or a demotion level, so that
  // cells keep crossing tiers in both directions.
  function automatic logic [POP_W-1:0] pick_population();
    int      k;
    longint  v;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      default: begin
        k = $urandom_range(1, 5);
        if ($urandom_range(0, 1) != 0) v = longint'(tracker.thr[k]);
        else v = longint'(tracker.demote_level(k));
        v = v + longint'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 64'h0000_0000_FFFF_FFFF) v = 64'h0000_0000_FFFF_FFFF;
        return v[31:0];
      end
    endcase
  endfunction

  task automatic send_random();
    logic [CELL_W-1:0] cell_idx;
    cmd_t              cmd;
    if ($urandom_range(0, 9) < 7) cell_idx = cell_pool[$urandom_range(0, 7)];
    else cell_idx = CELL_W'($urandom);
    cmd = ($urandom_range(0, 6) == 0) ? CMD_INIT : CMD_UPDATE;
    send_request(cmd, cell_idx, pick_population(), 1'($urandom));
  endtask

  // Keeps the write enable high across a run of writes; the caller drops it.
  task automatic put_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.write_reg(idx, v);
  endtask

  task automatic apply_config(logic [2:0] tc, logic [13:0] bp, logic [2:0] nt,
                              logic [31:0] t1, logic [31:0] t2, logic [31:0] t3,
                              logic [31:0] t4, logic [31:0] t5);
    // Upper bits of the narrow registers carry junk that must be dropped.
    put_reg(REG_TIER_COUNT, {29'($urandom), tc});
    put_reg(REG_DOWNGRADE, {18'($urandom), bp});
    put_reg(REG_NAMED_TIER, {29'($urandom), nt});
    put_reg(REG_THR_ONE, t1);
    put_reg(REG_THR_TWO, t2);
    put_reg(REG_THR_THREE, t3);
    put_reg(REG_THR_FOUR, t4);
    put_reg(REG_THR_FIVE, t5);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_random_config();
    logic [2:0]  tc;
    logic [13:0] bp;
    logic [31:0] t [1:5];
    logic [31:0] acc;
    case ($urandom_range(0, 9))
      0:       tc = 3'd0;
      1:       tc = 3'd7;
      default: tc = 3'($urandom_range(1, 6));
    endcase
    if ($urandom_range(0, 3) == 0) bp = 14'($urandom_range(10001, 16383));
    else bp = 14'($urandom_range(0, 10000));
    acc = $urandom_range(0, 50);
    for (int k = 1; k <= 5; k++) begin
      if ($urandom_range(0, 2) != 0) begin
        acc = acc + $urandom_range(0, 1 << $urandom_range(2, 20));
        t[k] = acc;
      end else begin
        t[k] = $urandom;
      end
    end
    apply_config(tc, bp, 3'($urandom_range(0, 7)), t[1], t[2], t[3], t[4], t[5]);
  endtask

  task automatic settle_out();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (tracker.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
  endtask

  // Runs under the reset configuration: boundaries, hysteresis and forced names.
  task automatic directed_requests();
    send_request(CMD_INIT, 12'd0, 32'd0, 1'b0);
    send_request(CMD_INIT, 12'd4095, 32'hFFFF_FFFF, 1'b0);
    send_request(CMD_UPDATE, 12'd4095, 32'd0, 1'b0);
    send_request(CMD_UPDATE, 12'd4095, 32'hFFFF_FFFF, 1'b1);
    send_request(CMD_UPDATE, 12'd4095, 32'd0, 1'b1);
    send_request(CMD_INIT, 12'd1, 32'd100, 1'b0);
    send_request(CMD_UPDATE, 12'd1, 32'd80, 1'b0);
    send_request(CMD_UPDATE, 12'd1, 32'd79, 1'b1);
    send_request(CMD_UPDATE, 12'd1, 32'd1000, 1'b0);
    send_request(CMD_UPDATE, 12'd1, 32'd999999, 1'b0);
    send_request(CMD_UPDATE, 12'd1, 32'd1000000, 1'b0);
    send_request(CMD_UPDATE, 12'd1, 32'd800000, 1'b0);
    send_request(CMD_UPDATE, 12'd1, 32'd799999, 1'b0);
    send_request(CMD_UPDATE, 12'd1, 32'd799999, 1'b0);
    send_request(CMD_INIT, 12'd1, 32'd5, 1'b0);
    send_request(CMD_UPDATE, 12'd2, 32'd10000, 1'b0);
    send_request(CMD_INIT, 12'd3, 32'd99, 1'b0);
    send_request(CMD_UPDATE, 12'd3, 32'd100, 1'b0);
    send_request(CMD_UPDATE, 12'd3, 32'd99, 1'b0);
    send_request(CMD_UPDATE, 12'd3, 32'd8000, 1'b0);
    send_request(CMD_UPDATE, 12'd3, 32'd0, 1'b0);
    send_request(CMD_UPDATE, 12'd4095, 32'h8000_0000, 1'b0);
    send_request(CMD_UPDATE, 12'd2730, 32'h5555_5555, 1'b1);
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    m_tready    = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    ready_phase = 0;
    burst_left  = 0;
    send_pace   = PACE_STEADY;
    drain_mode  = DRAIN_FULL;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_requests();
    send_pace = PACE_BURSTY;
    drain_mode <= DRAIN_RANDOM;
    repeat (100) send_random();
    settle_out();

    // Tier count above the maximum, full-strength demotion, every cell named.
    send_pace = PACE_STEADY;
    drain_mode <= DRAIN_FULL;
    apply_config(3'd7, 14'd10000, 3'd0, 32'd0, 32'd10, 32'd20, 32'd30, 32'd40);
    repeat (100) send_random();
    settle_out();

    // No tiers at all: every cell is forced to tier zero.
    send_pace = PACE_SPARSE;
    drain_mode <= DRAIN_STARVED;
    apply_config(3'd0, 14'd0, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (60) send_random();
    settle_out();

    // Three tiers while many cells still sit higher; demotion level above the threshold.
    send_pace = PACE_BURSTY;
    drain_mode <= DRAIN_PATTERN;
    apply_config(3'd3, 14'd16383, 3'd2, 32'd100, 32'd1000, 32'hFFFF_FFFF, 32'd5, 32'd0);
    repeat (100) send_random();
    settle_out();

    for (int p = 0; p < 5; p++) begin
      send_pace = send_pace_t'($urandom_range(0, 2));
      drain_mode <= drain_t'($urandom_range(0, 3));
      apply_random_config();
      repeat (80) send_random();
      settle_out();
    end

    send_pace = PACE_BURSTY;
    drain_mode <= DRAIN_RANDOM;
    apply_config(3'd1, 14'd1, 3'd1, 32'd7, 32'd70, 32'd700, 32'd7000, 32'd70000);
    repeat (80) send_random();
    settle_out();

    if (tracker.pending.size() != 0) begin
      $display("%0t: %0d results missing, expected 0 outstanding, actual %0d", $time,
               tracker.pending.size(), tracker.pending.size());
      tracker.errors += tracker.pending.size();
    end
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
